[rtl/core/sscd_pkg.sv]
// Shared types and constants for the serial speed command decoder.
`timescale 1ns / 1ps
`default_nettype none
package sscd_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_V     = 8'h76;

   localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
   localparam logic [30:0] SPEED_MAX = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      CLS_EOL,
      CLS_ZERO,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      CMD_STOP      = 3'd0,
      CMD_STATUS    = 3'd1,
      CMD_RECONNECT = 3'd2,
      CMD_ESTOP     = 3'd3,
      CMD_UP        = 3'd4,
      CMD_DOWN      = 3'd5,
      CMD_USAGE     = 3'd6
   } command_type;

   typedef struct packed {
      char_class_type cls;
      logic [7:0]     char_code;
      logic [3:0]     digit;
   } item_type;

   typedef struct packed {
      command_type command;
      logic [30:0] speed;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/serial_speed_command_decoder_core.sv]
// Top level of the serial speed command decoder.
//
// Input side is a queue write port: drive req_rx_byte and raise push; the
// word is taken at a rising edge where push is high and full is low.
// Result side is a queue read port: while empty is low the oldest
// command sits on rsp_command / rsp_speed, and it is taken at an edge where
// pop is high. A line of bytes ends at CR or LF; a non-empty line gives
// one result word, every other byte gives none.
// Throughput is one byte per cycle while the result side is not stalled.
// A classifier feeds a two-word queue; the line parser drains it one word
// a cycle (times-ten add on the value), and writes commands into a two-word
// result queue, so a line end is registered in both queues in turn.
// Reset clears both queues and the line state; no command is pending.
// When the result side stalls, the parser holds at the next line end and
// the input queue fills, after which full stays high until pop.
`timescale 1ns / 1ps
`default_nettype none
module serial_speed_command_decoder_core #(
   parameter int LINE_BUF_SIZE = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_command,
   output logic [30:0]      rsp_speed
);
   import sscd_pkg::*;

   localparam int ITEM_W   = $bits(item_type);
   localparam int RESULT_W = $bits(result_type);

   item_type   front_item;
   item_type   back_item;
   logic       mid_empty, mid_pop;
   logic       out_full, out_push;
   result_type back_result;
   result_type rsp_result;

   sscd_front u_front (
      .rx_byte (req_rx_byte),
      .item    (front_item)
   );

   sscd_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (2)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (mid_pop),
      .pop_data  (back_item),
      .empty     (mid_empty)
   );

   sscd_back #(
      .LINE_BUF_SIZE (LINE_BUF_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (mid_empty),
      .in_item    (back_item),
      .in_pop     (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (back_result)
   );

   sscd_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_result),
      .empty     (empty)
   );

   assign rsp_command = rsp_result.command;
   assign rsp_speed   = rsp_result.speed;

endmodule
`default_nettype wire

[rtl/core/sscd_fifo.sv]
// Small register-based word queue used between the decoder stages.
`timescale 1ns / 1ps
`default_nettype none
module sscd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == COUNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/sscd_front.sv]
// Front end: classifies each received byte for the line parser.
`timescale 1ns / 1ps
`default_nettype none
module sscd_front (
   input  wire logic [7:0]        rx_byte,
   output sscd_pkg::item_type     item
);
   import sscd_pkg::*;

   always_comb begin
      item.char_code = rx_byte;
      item.digit     = rx_byte[3:0];   // '0'..'9' carry their value in the low nibble
      case (rx_byte) inside
         CHAR_LF, CHAR_CR:                     item.cls = CLS_EOL;
         CHAR_NUL:                             item.cls = CLS_ZERO;
         CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF: item.cls = CLS_SPACE;
         CHAR_PLUS:                            item.cls = CLS_PLUS;
         CHAR_MINUS:                           item.cls = CLS_MINUS;
         [CHAR_ZERO:CHAR_NINE]:                item.cls = CLS_DIGIT;
         default:                              item.cls = CLS_OTHER;
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/sscd_back.sv]
// Back end: line assembly, incremental number parse and command decode.
`timescale 1ns / 1ps
`default_nettype none
module sscd_back #(
   parameter int LINE_BUF_SIZE = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_empty,
   input  wire sscd_pkg::item_type   in_item,
   output logic                      in_pop,
   input  wire logic                 out_full,
   output logic                      out_push,
   output sscd_pkg::result_type      out_result
);
   import sscd_pkg::*;

   localparam int CW = $clog2(LINE_BUF_SIZE);
   localparam logic [CW-1:0] STORE_MAX = CW'(LINE_BUF_SIZE - 1);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_NUM,
      PH_DONE
   } phase_type;

   logic [CW-1:0] stored_count_ff, stored_count_in;
   logic          has_text_ff, has_text_in;     // text_count >= 1
   logic          multi_text_ff, multi_text_in; // text_count >= 2
   logic          zero_seen_ff, zero_seen_in;
   logic [7:0]    first_char_ff, first_char_in;
   phase_type     phase_ff, phase_in;
   logic          negative_ff, negative_in;
   logic [31:0]   magnitude_ff, magnitude_in;

   logic          is_eol, emit, take;
   logic [35:0]   mag_next;
   logic [31:0]   mag_capped;
   logic          single_text;

   assign is_eol   = (in_item.cls == CLS_EOL);
   assign emit     = !in_empty && is_eol && (stored_count_ff != '0);
   assign in_pop   = !in_empty && (!emit || !out_full);
   assign take     = in_pop;
   assign out_push = emit && !out_full;

   // magnitude * 10 + digit, capped at 2^31
   assign mag_next   = ({4'b0, magnitude_ff} << 3) + ({4'b0, magnitude_ff} << 1)
                     + {32'b0, in_item.digit};
   assign mag_capped = (mag_next > {4'b0, MAG_CAP}) ? MAG_CAP : mag_next[31:0];

   assign single_text = has_text_ff && !multi_text_ff;

   always_comb begin
      out_result.command = CMD_USAGE;
      out_result.speed   = '0;
      if (single_text && first_char_ff == CHAR_S) begin
         out_result.command = CMD_STOP;
      end else if (single_text && first_char_ff == CHAR_I) begin
         out_result.command = CMD_STATUS;
      end else if (single_text && first_char_ff == CHAR_H) begin
         out_result.command = CMD_RECONNECT;
      end else if (single_text && first_char_ff == CHAR_E) begin
         out_result.command = CMD_ESTOP;
      end else if (has_text_ff && first_char_ff == CHAR_V) begin
         if (magnitude_ff == '0) begin
            out_result.command = CMD_STOP;
         end else begin
            out_result.command = negative_ff ? CMD_DOWN : CMD_UP;
            out_result.speed   = magnitude_ff[31] ? SPEED_MAX : magnitude_ff[30:0];
         end
      end
   end

   always_comb begin
      stored_count_in = stored_count_ff;
      has_text_in     = has_text_ff;
      multi_text_in   = multi_text_ff;
      zero_seen_in    = zero_seen_ff;
      first_char_in   = first_char_ff;
      phase_in        = phase_ff;
      negative_in     = negative_ff;
      magnitude_in    = magnitude_ff;
      if (take) begin
         if (is_eol) begin
            if (emit) begin
               stored_count_in = '0;
               has_text_in     = 1'b0;
               multi_text_in   = 1'b0;
               zero_seen_in    = 1'b0;
               first_char_in   = '0;
               phase_in        = PH_LEAD;
               negative_in     = 1'b0;
               magnitude_in    = '0;
            end
         end else if (stored_count_ff < STORE_MAX) begin
            stored_count_in = stored_count_ff + CW'(1);
            if (!zero_seen_ff) begin
               if (in_item.cls == CLS_ZERO) begin
                  zero_seen_in = 1'b1;
               end else if (!has_text_ff) begin
                  first_char_in = in_item.char_code;
                  has_text_in   = 1'b1;
               end else begin
                  multi_text_in = 1'b1;
                  case (phase_ff)
                     PH_LEAD: begin
                        if (in_item.cls == CLS_PLUS || in_item.cls == CLS_MINUS) begin
                           negative_in = (in_item.cls == CLS_MINUS);
                           phase_in    = PH_NUM;
                        end else if (in_item.cls == CLS_DIGIT) begin
                           magnitude_in = mag_capped;
                           phase_in     = PH_NUM;
                        end else if (in_item.cls != CLS_SPACE) begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_NUM: begin
                        if (in_item.cls == CLS_DIGIT) begin
                           magnitude_in = mag_capped;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: begin
                        phase_in = PH_DONE;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff <= '0;
         has_text_ff     <= 1'b0;
         multi_text_ff   <= 1'b0;
         zero_seen_ff    <= 1'b0;
         first_char_ff   <= '0;
         phase_ff        <= PH_LEAD;
         negative_ff     <= 1'b0;
         magnitude_ff    <= '0;
      end else begin
         stored_count_ff <= stored_count_in;
         has_text_ff     <= has_text_in;
         multi_text_ff   <= multi_text_in;
         zero_seen_ff    <= zero_seen_in;
         first_char_ff   <= first_char_in;
         phase_ff        <= phase_in;
         negative_ff     <= negative_in;
         magnitude_ff    <= magnitude_in;
      end
   end

   a_speed_only_on_move: assert property (@(posedge clock) disable iff (reset)
      out_push && out_result.speed != '0 |->
         out_result.command == CMD_UP || out_result.command == CMD_DOWN)
      else $error("nonzero speed on a non-move command");

   a_line_cleared_after_emit: assert property (@(posedge clock) disable iff (reset)
      out_push |=> stored_count_ff == '0 && !has_text_ff && magnitude_ff == '0)
      else $error("line state not cleared after a command");

   a_magnitude_capped: assert property (@(posedge clock) disable iff (reset)
      magnitude_ff <= MAG_CAP)
      else $error("magnitude exceeds cap");

   a_text_order: assert property (@(posedge clock) disable iff (reset)
      multi_text_ff |-> has_text_ff && stored_count_ff >= CW'(2))
      else $error("text flags inconsistent with kept count");

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      emit && out_full |-> !in_pop)
      else $error("line end consumed while result queue full");

endmodule
`default_nettype wire
